// ===== sv/websocket_frame_deframer_defines.svh =====
// ----------------------------------------------------------------------------
// websocket frame deframer assertion macros
// shared concurrent check wrappers, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// same-cycle implication
`define WSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsd_pkg
// types and constants shared by the websocket frame deframer
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int unsigned PAYLOAD_LEN_W = 63;
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned QUEUE_AW      = 2;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  localparam logic [6:0] LEN_CODE16 = 7'd126;
  localparam logic [6:0] LEN_CODE64 = 7'd127;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  typedef enum logic [2:0] {
    PH_B0    = 3'd0,
    PH_B1    = 3'd1,
    PH_EXT16 = 3'd2,
    PH_EXT64 = 3'd3,
    PH_KEY   = 3'd4,
    PH_DATA  = 3'd5
  } phase_t;

  typedef struct packed {
    logic                     kind;
    logic                     fin;
    logic [3:0]               opcode;
    logic                     masked;
    logic [PAYLOAD_LEN_W-1:0] payload_length;
    logic [7:0]               raw_byte;
    logic [7:0]               key_byte;
    logic                     last;
  } wsd_item_t;

  typedef struct packed {
    logic nonempty;
    logic full;
  } wsd_qstat_t;

endpackage

// ===== sv/wsd_if.sv =====
// ----------------------------------------------------------------------------
// wsd channel interfaces
// byte input channel and parsed result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface wsd_out_if import wsd_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic                     fin;
  logic [3:0]               opcode;
  logic                     masked;
  logic [PAYLOAD_LEN_W-1:0] payload_length;
  logic [7:0]               data;
  logic                     last;

  modport source (
    output valid, output kind, output fin, output opcode, output masked,
    output payload_length, output data, output last, input ready
  );
  modport sink (
    input valid, input kind, input fin, input opcode, input masked,
    input payload_length, input data, input last, output ready
  );
endinterface

// ===== sv/websocket_frame_deframer.sv =====
// a result is queued as its byte is taken, then moved to the output register
// throughput: one byte per cycle while the queue is not full, set by the parser
// a 4-entry queue and the output register let input and output stall apart
// reset: synchronous active-low rst_n, parser back to waiting for header byte 0
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// byte-serial websocket frame parser with payload unmasking
// ----------------------------------------------------------------------------
`include "websocket_frame_deframer_defines.svh"

module websocket_frame_deframer import wsd_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 63
) (
  input  logic      clk,
  input  logic      rst_n,
  wsd_in_if.sink    in_chan,
  wsd_out_if.source out_chan
);

  wsd_qstat_t q_stat;
  logic       q_push;
  logic       q_pop;
  wsd_item_t  q_push_item;
  wsd_item_t  q_head_item;
  logic       in_ready;

  assign in_chan.ready = in_ready;

  wsd_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_rx_byte (in_chan.rx_byte),
    .in_ready   (in_ready),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_item     (q_push_item)
  );

  wsd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .pop       (q_pop),
    .head_item (q_head_item),
    .stat      (q_stat)
  );

  wsd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .q_item   (q_head_item),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

  `WSD_ASSERT_NOW(a_no_overflow, q_push, !q_stat.full, "result queue overflow")
  `WSD_ASSERT_NOW(a_empty_hdr_last,
                  out_chan.valid && (out_chan.kind == KIND_HEADER) && out_chan.last,
                  out_chan.payload_length == '0,
                  "header marked last with nonzero length")
  `WSD_ASSERT_NOW(a_hdr_data_zero,
                  out_chan.valid && (out_chan.kind == KIND_HEADER),
                  out_chan.data == 8'd0,
                  "header item carries data")
  `WSD_ASSERT_NEXT(a_pop_shows, q_pop, out_chan.valid, "popped item not presented")

endmodule

// ===== sv/wsd_front.sv =====
// ----------------------------------------------------------------------------
// wsd_front
// parser: one byte per cycle unless queue full, tracks state, queues results
// ----------------------------------------------------------------------------
module wsd_front import wsd_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 63
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_rx_byte,
  output logic       in_ready,
  input  wsd_qstat_t q_stat,
  output logic       q_push,
  output wsd_item_t  q_item
);

  phase_t                 phase_r, phase_nxt;
  logic [3:0]             cnt_r, cnt_nxt;
  logic                   fin_r, fin_nxt;
  logic [3:0]             opcode_r, opcode_nxt;
  logic                   masked_r, masked_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [31:0]            key_r, key_nxt;
  logic [LENGTH_BITS-1:0] remain_r, remain_nxt;
  logic [1:0]             kidx_r, kidx_nxt;

  logic                   accept;
  logic                   len_done;
  logic                   hdr_done;
  logic                   data_res;
  logic                   data_last;
  logic [LENGTH_BITS-1:0] remain_dec;
  logic [7:0]             key_sel;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  assign remain_dec = (remain_r != '0) ? remain_r - LENGTH_BITS'(1) : remain_r;

  always_comb begin
    unique case (kidx_r)
      2'd0:    key_sel = key_r[31:24];
      2'd1:    key_sel = key_r[23:16];
      2'd2:    key_sel = key_r[15:8];
      default: key_sel = key_r[7:0];
    endcase
  end

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    fin_nxt    = fin_r;
    opcode_nxt = opcode_r;
    masked_nxt = masked_r;
    len_nxt    = len_r;
    key_nxt    = key_r;
    remain_nxt = remain_r;
    kidx_nxt   = kidx_r;
    len_done   = 1'b0;
    hdr_done   = 1'b0;
    data_res   = 1'b0;
    data_last  = 1'b0;
    unique case (phase_r)
      PH_B1: begin
        masked_nxt = in_rx_byte[7];
        key_nxt    = '0;
        len_nxt    = '0;
        cnt_nxt    = '0;
        if (in_rx_byte[6:0] == LEN_CODE16) begin
          phase_nxt = PH_EXT16;
        end else if (in_rx_byte[6:0] == LEN_CODE64) begin
          phase_nxt = PH_EXT64;
        end else begin
          len_nxt  = LENGTH_BITS'(in_rx_byte[6:0]);
          len_done = 1'b1;
        end
      end
      PH_EXT16, PH_EXT64: begin
        len_nxt = {len_r[LENGTH_BITS-9:0], in_rx_byte};
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_nxt >= ((phase_r == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES)) begin
          len_done = 1'b1;
        end
      end
      PH_KEY: begin
        key_nxt = {key_r[23:0], in_rx_byte};
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_nxt >= KEY_BYTES) begin
          hdr_done = 1'b1;
        end
      end
      PH_DATA: begin
        data_res   = 1'b1;
        kidx_nxt   = kidx_r + 2'd1;
        remain_nxt = remain_dec;
        data_last  = (remain_dec == '0);
        if (data_last) begin
          phase_nxt = PH_B0;
          kidx_nxt  = '0;
        end
      end
      default: begin
        fin_nxt    = in_rx_byte[7];
        opcode_nxt = in_rx_byte[3:0];
        cnt_nxt    = '0;
        phase_nxt  = PH_B1;
      end
    endcase
    if (len_done) begin
      cnt_nxt = '0;
      if (masked_nxt) begin
        phase_nxt = PH_KEY;
      end else begin
        hdr_done = 1'b1;
      end
    end
    if (hdr_done) begin
      remain_nxt = len_nxt;
      kidx_nxt   = '0;
      cnt_nxt    = '0;
      phase_nxt  = (len_nxt == '0) ? PH_B0 : PH_DATA;
    end
  end

  // result item
  always_comb begin
    q_push                = accept && (hdr_done || data_res);
    q_item.kind           = data_res ? KIND_DATA : KIND_HEADER;
    q_item.fin            = fin_nxt;
    q_item.opcode         = opcode_nxt;
    q_item.masked         = masked_nxt;
    q_item.payload_length = PAYLOAD_LEN_W'(len_nxt);
    q_item.raw_byte       = data_res ? in_rx_byte : 8'd0;
    q_item.key_byte       = key_sel;
    q_item.last           = data_res ? data_last : (len_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_B0;
      cnt_r    <= '0;
      fin_r    <= 1'b0;
      opcode_r <= '0;
      masked_r <= 1'b0;
      len_r    <= '0;
      key_r    <= '0;
      remain_r <= '0;
      kidx_r   <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      fin_r    <= fin_nxt;
      opcode_r <= opcode_nxt;
      masked_r <= masked_nxt;
      len_r    <= len_nxt;
      key_r    <= key_nxt;
      remain_r <= remain_nxt;
      kidx_r   <= kidx_nxt;
    end
  end

endmodule

// ===== sv/wsd_queue.sv =====
// ----------------------------------------------------------------------------
// wsd_queue
// short result queue between the parser and the output stage
// ----------------------------------------------------------------------------
module wsd_queue import wsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  wsd_item_t  push_item,
  input  logic       pop,
  output wsd_item_t  head_item,
  output wsd_qstat_t stat
);

  wsd_item_t           store_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]   count_r, count_nxt;

  assign head_item     = store_r[rd_ptr_r];
  assign stat.nonempty = (count_r != '0);
  assign stat.full     = (count_r == (QUEUE_AW + 1)'(QUEUE_DEPTH));

  always_comb begin
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ===== sv/wsd_back.sv =====
// ----------------------------------------------------------------------------
// wsd_back
// output stage: unmasks payload bytes and holds the result register
// ----------------------------------------------------------------------------
module wsd_back import wsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  wsd_qstat_t q_stat,
  input  wsd_item_t  q_item,
  output logic       q_pop,
  wsd_out_if.source  out_chan
);

  logic                     valid_r;
  logic                     kind_r;
  logic                     fin_r;
  logic [3:0]               opcode_r;
  logic                     masked_r;
  logic [PAYLOAD_LEN_W-1:0] len_r;
  logic [7:0]               data_r, data_nxt;
  logic                     last_r;

  assign q_pop = q_stat.nonempty && (!valid_r || out_chan.ready);

  always_comb begin
    if (q_item.kind == KIND_DATA) begin
      data_nxt = q_item.masked ? (q_item.raw_byte ^ q_item.key_byte) : q_item.raw_byte;
    end else begin
      data_nxt = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r   <= q_item.kind;
      fin_r    <= q_item.fin;
      opcode_r <= q_item.opcode;
      masked_r <= q_item.masked;
      len_r    <= q_item.payload_length;
      data_r   <= data_nxt;
      last_r   <= q_item.last;
    end
  end

  assign out_chan.valid          = valid_r;
  assign out_chan.kind           = kind_r;
  assign out_chan.fin            = fin_r;
  assign out_chan.opcode         = opcode_r;
  assign out_chan.masked         = masked_r;
  assign out_chan.payload_length = len_r;
  assign out_chan.data           = data_r;
  assign out_chan.last           = last_r;

endmodule
